[sv/first_match_packet_rule_classifier_assert.svh]
// assertion macros for the first-match packet rule classifier
`ifndef FIRST_MATCH_PACKET_RULE_CLASSIFIER_ASSERT_SVH
`define FIRST_MATCH_PACKET_RULE_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define FMPRC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define FMPRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FMPRC_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define FMPRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/fmprc_pkg.sv]
// shared types, codes and match functions of the packet rule classifier
`timescale 1ns / 1ps
package fmprc_pkg;

  localparam int MaxRulesDef = 16;

  localparam logic [16:0] PortAny  = 17'h1FFFF;
  localparam logic [1:0]  ProtoAny = 2'd2;
  localparam logic [10:0] DayLast  = 11'd1439;
  localparam logic [5:0]  PrefixMax = 6'd32;

  typedef enum logic [1:0] {
    FUNC_CLASSIFY = 2'd0,
    FUNC_ADD      = 2'd1,
    FUNC_REMOVE   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [5:0]  src_len;
    logic [31:0] dst_addr;
    logic [5:0]  dst_len;
    logic [16:0] sport;
    logic [16:0] dport;
    logic [1:0]  proto;
    logic [10:0] win_start;
    logic [10:0] win_end;
    logic        allow;
  } rule_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [16:0] sport;
    logic [16:0] dport;
    logic [1:0]  proto;
    logic [10:0] now;
  } pkt_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic       valid;
    logic       found;
    logic       allow;
    logic [3:0] idx;
  } tok_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic load_new;
    logic load_next;
    logic active;
  } cell_ctl_t;

  function automatic logic prefix_hit(logic [31:0] addr, logic [31:0] base,
                                      logic [5:0] len);
    logic [31:0] mask;
    mask = ~(32'hFFFF_FFFF >> len);
    if (len == 6'd0) begin
      return 1'b1;
    end else if (len > PrefixMax) begin
      return 1'b0;
    end
    return ((addr ^ base) & mask) == 32'd0;
  endfunction

  function automatic logic rule_hit(rule_t r, pkt_t p);
    logic src_ok, dst_ok, sp_ok, dp_ok, pr_ok, tm_ok;
    src_ok = prefix_hit(p.src_ip, r.src_addr, r.src_len);
    dst_ok = prefix_hit(p.dst_ip, r.dst_addr, r.dst_len);
    sp_ok  = (r.sport == PortAny) || (r.sport == p.sport);
    dp_ok  = (r.dport == PortAny) || (r.dport == p.dport);
    pr_ok  = (r.proto == ProtoAny) || (r.proto == p.proto);
    tm_ok  = ((r.win_start == 11'd0) && (r.win_end >= DayLast)) ||
             ((p.now >= r.win_start) && (p.now <= r.win_end));
    return src_ok && dst_ok && sp_ok && dp_ok && pr_ok && tm_ok;
  endfunction

endpackage

[sv/fmprc_cell.sv]
// one rule cell: holds a rule, shifts on remove, checks the passing token
`timescale 1ns / 1ps
module fmprc_cell import fmprc_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  rule_t     new_rule_i,
  input  rule_t     next_rule_i,
  input  pkt_t      pkt_i,
  input  tok_t      tok_i,
  output rule_t     rule_o,
  output tok_t      tok_o
);

  rule_t rule_q, rule_d;
  tok_t  tok_q, tok_d;
  logic  hit;

  // rule storage: append or pull from the neighbor below
  always_comb begin
    rule_d = rule_q;
    if (ctl_i.load_new) begin
      rule_d = new_rule_i;
    end else if (ctl_i.load_next) begin
      rule_d = next_rule_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rule_q <= rule_d;
  end

  // first match wins: an earlier hit passes through untouched
  assign hit = ctl_i.active && rule_hit(rule_q, pkt_i);

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.found && hit) begin
      tok_d.found = 1'b1;
      tok_d.allow = rule_q.allow;
      tok_d.idx   = 4'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign rule_o = rule_q;
  assign tok_o  = tok_q;

endmodule

[sv/first_match_packet_rule_classifier.sv]
// top level of the first-match packet rule classifier
//
// Input channel in_valid_i / in_ready_o moves one word (func_i plus rule or
// packet fields). Output channel out_valid_o / out_ready_i moves one result
// word per input word.
// Rules live in a row of MAX_RULES cells in table order. Add writes the cell
// at the current count, remove makes every cell from the index on but the
// last load the rule of its lower neighbor; the result is registered and
// appears in the cycle after the input word is taken.
// Classify sends a search token down the row, one cell per cycle; the token
// keeps the first hit. The word passes the start register, the token
// register of each cell in turn and then the output register. Input is taken
// one word at a time: no word is taken while a classify scans the row.
// A new word is taken while the sequencer is idle and the output register
// is empty or is being read in the same cycle; while the receiver stalls, a
// waiting result holds the input off. Reset empties the table (count zero)
// and the output register; rule contents are not cleared.
`timescale 1ns / 1ps
`include "first_match_packet_rule_classifier_assert.svh"
module first_match_packet_rule_classifier import fmprc_pkg::*; #(
  parameter int MAX_RULES = MaxRulesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  logic [31:0]        src_ip_i,
  input  logic [31:0]        dst_ip_i,
  input  logic signed [16:0] src_port_i,
  input  logic signed [16:0] dst_port_i,
  input  logic [1:0]         proto_i,
  input  logic [5:0]         src_prefix_len_i,
  input  logic [5:0]         dst_prefix_len_i,
  input  logic [10:0]        time_lo_i,
  input  logic [10:0]        time_hi_i,
  input  logic               allow_action_i,
  input  logic [3:0]         rule_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               allowed_o,
  output logic               matched_o,
  output logic [3:0]         match_index_o,
  output logic [1:0]         status_o
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_RULES);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             start_q, start_d;
  pkt_t             pkt_q;
  rule_t            new_rule;
  logic             in_fire, add_go, rm_go;
  logic [CMP_W-1:0] rm_idx, cnt_ext;

  logic             out_valid_q, out_valid_d;
  logic             allowed_q, allowed_d, matched_q, matched_d;
  logic [3:0]       idx_q, idx_d;
  logic [1:0]       status_q, status_d;
  logic             res_load;

  rule_t     cell_rule [MAX_RULES];
  tok_t      tok       [MAX_RULES+1];
  cell_ctl_t cell_ctl  [MAX_RULES];

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign rm_idx  = CMP_W'(rule_index_i);
  assign cnt_ext = CMP_W'(count_q);
  assign add_go  = in_fire && (func_i == FUNC_ADD) && (count_q < CntMax);
  assign rm_go   = in_fire && (func_i == FUNC_REMOVE) && (rm_idx < cnt_ext);

  // rule word built from the input fields
  always_comb begin
    new_rule.src_addr  = src_ip_i;
    new_rule.src_len   = src_prefix_len_i;
    new_rule.dst_addr  = dst_ip_i;
    new_rule.dst_len   = dst_prefix_len_i;
    new_rule.sport     = src_port_i;
    new_rule.dport     = dst_port_i;
    new_rule.proto     = proto_i;
    new_rule.win_start = time_lo_i;
    new_rule.win_end   = time_hi_i;
    new_rule.allow     = allow_action_i;
  end

  // packet held steady while the token walks the row
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pkt_q.src_ip <= src_ip_i;
      pkt_q.dst_ip <= dst_ip_i;
      pkt_q.sport  <= src_port_i;
      pkt_q.dport  <= dst_port_i;
      pkt_q.proto  <= proto_i;
      pkt_q.now    <= time_lo_i;
    end
  end

  assign tok[0] = '{valid: start_q, found: 1'b0, allow: 1'b0, idx: 4'd0};

  // the cell row
  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    rule_t next_rule;

    assign cell_ctl[i].load_new  = add_go && (count_q == CNT_W'(i));
    assign cell_ctl[i].load_next = rm_go && (CMP_W'(i) >= rm_idx) &&
                                   (i + 1 < MAX_RULES);
    assign cell_ctl[i].active    = count_q > CNT_W'(i);

    if (i + 1 < MAX_RULES) begin : g_next
      assign next_rule = cell_rule[i+1];
    end else begin : g_last
      assign next_rule = cell_rule[i];
    end

    fmprc_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cell_ctl[i]),
      .new_rule_i (new_rule),
      .next_rule_i(next_rule),
      .pkt_i      (pkt_q),
      .tok_i      (tok[i]),
      .rule_o     (cell_rule[i]),
      .tok_o      (tok[i+1])
    );
  end

  // sequencer, count and result selection
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    start_d     = 1'b0;
    res_load    = 1'b0;
    allowed_d   = 1'b0;
    matched_d   = 1'b0;
    idx_d       = 4'd0;
    status_d    = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (func_i)
            FUNC_CLASSIFY: begin
              state_d = S_SCAN;
              start_d = 1'b1;
            end
            FUNC_ADD: begin
              res_load = 1'b1;
              if (add_go) begin
                count_d = count_q + CNT_W'(1);
              end else begin
                status_d = ST_FULL;
              end
            end
            FUNC_REMOVE: begin
              res_load = 1'b1;
              if (rm_go) begin
                count_d = count_q - CNT_W'(1);
              end else begin
                status_d = ST_BAD_INDEX;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tok[MAX_RULES].valid) begin
          state_d   = S_IDLE;
          res_load  = 1'b1;
          matched_d = tok[MAX_RULES].found;
          allowed_d = tok[MAX_RULES].found && tok[MAX_RULES].allow;
          idx_d     = tok[MAX_RULES].found ? tok[MAX_RULES].idx : 4'd0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      allowed_q <= allowed_d;
      matched_q <= matched_d;
      idx_q     <= idx_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign allowed_o     = allowed_q;
  assign matched_o     = matched_q;
  assign match_index_o = idx_q;
  assign status_o      = status_q;

  // checks
  `FMPRC_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CntMax)
  `FMPRC_ASSERT_ALWAYS(a_scan_out_empty, clk_i, rst_ni,
                       !(state_q == S_SCAN) || !out_valid_q)
  `FMPRC_ASSERT_ALWAYS(a_token_in_scan, clk_i, rst_ni,
                       !tok[MAX_RULES].valid || (state_q == S_SCAN))
  `FMPRC_ASSERT_NEXT(a_add_counts, clk_i, rst_ni, add_go,
                     (count_q == $past(count_q) + CNT_W'(1)) && out_valid_q)

endmodule
